// ===== rtl/core/websocket_header_parser_defines.svh =====
// Assertion macros for the WebSocket header parser.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef WEBSOCKET_HEADER_PARSER_DEFINES_SVH
`define WEBSOCKET_HEADER_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSHP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("websocket_header_parser: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define WSHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("websocket_header_parser: next-cycle check failed");

`endif

// ===== rtl/core/wshp_pkg.sv =====
// Shared types and constants for the WebSocket header parser.
// No dependencies; used by wshp_decode, wshp_out_buf and the top level.
package wshp_pkg;

  localparam int unsigned LenW   = 64;
  localparam int unsigned HsizeW = 4;
  localparam int unsigned OpW    = 4;
  localparam int unsigned ResW   = HsizeW + LenW + 1 + OpW;
  localparam int unsigned OutTdataW = ((ResW + 7) / 8) * 8;

  // Packed from the low bit up: opcode, masked, payload_length, hdr_bytes.
  typedef struct packed {
    logic [HsizeW-1:0] hdr_bytes;
    logic [LenW-1:0]   payload_length;
    logic              masked;
    logic [OpW-1:0]    opcode;
  } res_t;

  localparam logic [6:0] LenCodeMax16 = 7'd126;
  localparam logic [6:0] LenCodeMax7  = 7'd125;

  localparam logic [HsizeW-1:0] HsizeBase  = 4'd2;
  localparam logic [HsizeW-1:0] HsizeExt16 = 4'd4;
  localparam logic [HsizeW-1:0] HsizeExt64 = 4'd10;
  localparam logic [HsizeW-1:0] HsizeMask  = 4'd4;
  localparam logic [HsizeW-1:0] HsizeMaxAll = 4'd14;

  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;

endpackage

// ===== rtl/core/wshp_decode.sv =====
// Header decode stage: parser state and its next-state logic.
// Depends on wshp_pkg for the result type and length constants.
module wshp_decode import wshp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       start_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhSecond = 2'd1;
  localparam logic [1:0] PhExt    = 2'd2;
  localparam logic [1:0] PhDone   = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic [LenW-1:0]   acc_q, acc_d;
  logic [3:0]        left_q, left_d;
  logic [OpW-1:0]    op_q, op_d;
  logic              mask_q, mask_d;
  logic [HsizeW-1:0] hsize_q, hsize_d;
  logic              emit;
  logic [6:0]        code;
  logic [HsizeW-1:0] extra;
  logic [3:0]        left_dec;

  assign code     = byte_i[6:0];
  assign extra    = byte_i[7] ? HsizeMask : '0;
  assign left_dec = left_q - 4'd1;

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    left_d  = left_q;
    op_d    = op_q;
    mask_d  = mask_q;
    hsize_d = hsize_q;
    emit    = 1'b0;
    if (fire_i) begin
      if (start_i) begin
        op_d    = byte_i[OpW-1:0];
        mask_d  = 1'b0;
        hsize_d = '0;
        acc_d   = '0;
        left_d  = '0;
        phase_d = PhSecond;
      end else begin
        unique case (phase_q)
          PhSecond: begin
            mask_d = byte_i[7];
            if (code <= LenCodeMax7) begin
              acc_d   = {{(LenW-7){1'b0}}, code};
              hsize_d = HsizeBase + extra;
              phase_d = PhDone;
              emit    = 1'b1;
            end else begin
              acc_d   = '0;
              phase_d = PhExt;
              if (code == LenCodeMax16) begin
                left_d  = ExtBytes16;
                hsize_d = HsizeExt16 + extra;
              end else begin
                left_d  = ExtBytes64;
                hsize_d = HsizeExt64 + extra;
              end
            end
          end
          PhExt: begin
            acc_d = {acc_q[LenW-9:0], byte_i};
            if (left_q != '0) begin
              left_d = left_dec;
            end
            if (left_q == '0 || left_dec == '0) begin
              phase_d = PhDone;
              emit    = 1'b1;
            end
          end
          PhIdle, PhDone: begin
            // drop stray bytes until the next start
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      acc_q   <= '0;
      left_q  <= '0;
      op_q    <= '0;
      mask_q  <= 1'b0;
      hsize_q <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      op_q    <= op_d;
      mask_q  <= mask_d;
      hsize_q <= hsize_d;
    end
  end

  assign res_valid_o          = emit;
  assign res_o.opcode         = op_d;
  assign res_o.masked         = mask_d;
  assign res_o.payload_length = acc_d;
  assign res_o.hdr_bytes      = hsize_d;

endmodule

// ===== rtl/core/wshp_out_buf.sv =====
// Result register with a skid entry; the decode stage waits on tready only once both are full.
// Depends on wshp_pkg for the result type.
module wshp_out_buf import wshp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic out_valid_q, skid_valid_q;
  res_t out_data_q, skid_data_q;
  logic pop;

  assign pop = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push_i;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_data_q <= skid_valid_q ? skid_data_q : push_data_i;
      if (skid_valid_q && push_i) begin
        skid_data_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_data_q <= push_data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/websocket_header_parser.sv =====
// WebSocket frame header parser, top level: input register, decode, result buffer.
// Depends on wshp_pkg, wshp_decode, wshp_out_buf and the assertion macro header.
//
// Usage: header bytes enter on the s_axis channel one beat each, in wire order,
// with tuser high on the first byte of a header. A high tuser always restarts
// parsing and abandons a header in progress. Once the 7-, 16- or 64-bit length
// is complete, one result beat leaves on m_axis carrying opcode, mask flag,
// payload length and total header size (masking key included). Other bytes,
// such as the masking key and payload, produce no beat.
// Path: an accepted byte is held in the input register, decoded combinationally
// from there, and its result is registered in the result buffer for m_axis.
// Throughput: one byte per cycle; the input register and the decode stage
// each take a beat every cycle while the result buffer has a free entry.
// When the receiver stalls, results queue in the two-entry result buffer;
// once both are full the decode stage holds and s_axis_tready drops once the input register holds a byte.
// Reset: all parser state clears to idle and both channels come up empty.
`include "websocket_header_parser_defines.svh"

module websocket_header_parser import wshp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
  input  logic                 s_axis_tuser,  // [0] start_req
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [3:0] opcode, [4] masked, [68:5] payload_length, [72:69] hdr_bytes,
  // upper bits zero
  output logic [OutTdataW-1:0] m_axis_tdata
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       fire;
  logic       buf_full;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  assign fire          = in_valid_q && !buf_full;
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  wshp_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .start_i     (in_start_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wshp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {{(OutTdataW-ResW){1'b0}}, out_res};

  // An empty result buffer must never hold off input.
  `WSHP_ASSERT_NOW(a_empty_ready, !m_axis_tvalid, s_axis_tready)
  // A decoded result leaves m_axis_tvalid high in the next cycle.
  `WSHP_ASSERT_NEXT(a_res_shown, res_valid, m_axis_tvalid)
  // Header size is one of the legal totals.
  `WSHP_ASSERT_NOW(a_hsize_legal, m_axis_tvalid,
    out_res.hdr_bytes == HsizeBase || out_res.hdr_bytes == HsizeExt16 ||
    out_res.hdr_bytes == (HsizeBase + HsizeMask) ||
    out_res.hdr_bytes == (HsizeExt16 + HsizeMask) ||
    out_res.hdr_bytes == HsizeExt64 || out_res.hdr_bytes == HsizeMaxAll)

endmodule
